/* rtl/crtb_pkg.sv */
// shared types, codes and constants for the cascaded reload timer bank
package crtb_pkg;

	localparam int CHANNELS = 4;
	localparam int IRQ_W = 4;
	localparam int DIV_W = 12;
	localparam int CNT_W = 16;

	localparam logic [7:0] MASK_FIRST = 8'hC3;
	localparam logic [7:0] MASK_OTHER = 8'hC7;

	localparam int CTL_CASCADE = 2;
	localparam int CTL_IRQ = 6;
	localparam int CTL_START = 7;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_READ  = 2'd1,
		KIND_WRITE = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		BYTE_LO   = 2'd0,
		BYTE_HI   = 2'd1,
		BYTE_CTL  = 2'd2,
		BYTE_CTLH = 2'd3
	} byte_sel_t;

	typedef struct packed {
		logic       tick;
		logic       wr_lo;
		logic       wr_hi;
		logic       wr_ctl;
		logic [7:0] data;
	} chan_cmd_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic [7:0]       ctl;
		logic             wrap;
		logic             irq;
	} chan_stat_t;

	// low divider bits that must be zero for a prescaled count (2, 128, 512, 4096)
	function automatic logic [DIV_W-1:0] prescale_mask(input logic [1:0] sel);
		logic [DIV_W-1:0] m;
		unique case (sel)
			2'd0: m = 12'h001;
			2'd1: m = 12'h07F;
			2'd2: m = 12'h1FF;
			2'd3: m = 12'hFFF;
			default: m = 12'hFFF;
		endcase
		return m;
	endfunction

endpackage

/* rtl/crtb_if.sv */
// request and response channel interfaces of the timer bank
interface crtb_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [3:0] reg_offset;
	logic [7:0] write_data;

	modport source(output valid, kind, reg_offset, write_data, input ready);
	modport sink(input valid, kind, reg_offset, write_data, output ready);
endinterface

interface crtb_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic [3:0] irq_raised;

	modport source(output valid, read_data, irq_raised, input ready);
	modport sink(input valid, read_data, irq_raised, output ready);
endinterface

/* rtl/crtb_channel.sv */
// one timer channel: count, reload and control registers with wrap and cascade logic
module crtb_channel (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           is_first,
	input  crtb_pkg::chan_cmd_t            cmd,
	input  logic [crtb_pkg::DIV_W-1:0]     next_div,
	input  logic                           carry_in,
	output crtb_pkg::chan_stat_t           stat
);

	logic [crtb_pkg::CNT_W-1:0] count_q;
	logic [crtb_pkg::CNT_W-1:0] reload_q;
	logic [7:0]                 ctl_q;
	logic                       started;
	logic                       cascaded;
	logic                       hit;
	logic                       bump;
	logic                       wrap;
	logic [7:0]                 new_ctl;

	assign started  = ctl_q[crtb_pkg::CTL_START];
	assign cascaded = ctl_q[crtb_pkg::CTL_CASCADE] && !is_first;
	assign hit      = (next_div & crtb_pkg::prescale_mask(ctl_q[1:0])) == '0;
	assign bump     = cmd.tick && started && (cascaded ? carry_in : hit);
	assign wrap     = bump && (count_q == '1);
	assign new_ctl  = cmd.data & (is_first ? crtb_pkg::MASK_FIRST : crtb_pkg::MASK_OTHER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			reload_q <= '0;
			ctl_q    <= '0;
		end else begin
			if (bump) begin
				count_q <= wrap ? reload_q : count_q + 16'd1;
			end
			if (cmd.wr_lo) begin
				reload_q[7:0] <= cmd.data;
			end
			if (cmd.wr_hi) begin
				reload_q[15:8] <= cmd.data;
			end
			if (cmd.wr_ctl) begin
				ctl_q <= new_ctl;
				// start edge loads the count from reload
				if (!started && new_ctl[crtb_pkg::CTL_START]) begin
					count_q <= reload_q;
				end
			end
		end
	end

	assign stat.count = count_q;
	assign stat.ctl   = ctl_q;
	assign stat.wrap  = wrap;
	assign stat.irq   = wrap && ctl_q[crtb_pkg::CTL_IRQ];

endmodule

/* rtl/cascaded_reload_timer_bank_unit.sv */
// top level of the cascaded reload timer bank
//
// usage: items arrive on req (kind, reg_offset, write_data) with a valid/ready
// handshake; every item gives exactly one item on rsp (read_data, irq_raised).
// a tick item advances the 12-bit divider and the started channels, a read
// item returns a count or control byte, a write item updates reload or control.
// an accepted item is registered in the input stage, then processed as it
// moves on into the response register, which drives rsp; a stalled rsp can
// hold it in the input stage.
// throughput: one item per cycle while rsp takes its items; the divider, the
// four channel counters and the cascade chain all update as the item is processed.
// when rsp stalls, the response register holds and one more item waits in the
// input stage; req.ready then drops until rsp takes its item.
// reset clears the divider, all counts, reloads and control bytes (all
// channels stopped) and empties both pipeline stages.
module cascaded_reload_timer_bank_unit (
	input  logic       clk,
	input  logic       arst_n,
	crtb_req_if.sink   req,
	crtb_rsp_if.source rsp
);

	localparam int N = crtb_pkg::CHANNELS;

	logic       valid_s1;
	logic [1:0] kind_s1;
	logic [3:0] offset_s1;
	logic [7:0] data_s1;
	logic       advance;

	logic       valid_s2;
	logic [7:0] read_data_s2;
	logic [3:0] irq_s2;

	logic [crtb_pkg::DIV_W-1:0] div_q;
	logic [crtb_pkg::DIV_W-1:0] next_div;

	logic [1:0] ch_sel;
	logic [1:0] byte_sel;
	logic       ch_ok;
	logic       is_tick;
	logic       is_read;
	logic       is_write;

	crtb_pkg::chan_cmd_t  cmd  [N];
	crtb_pkg::chan_stat_t stat [N];
	logic [N:0]           carry;

	logic [7:0]                read_val;
	logic [crtb_pkg::IRQ_W-1:0] irq_vec;

	// pipeline handshake
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			kind_s1   <= req.kind;
			offset_s1 <= req.reg_offset;
			data_s1   <= req.write_data;
		end
	end

	// decode of the item in the input stage
	assign ch_sel   = offset_s1[3:2];
	assign byte_sel = offset_s1[1:0];
	assign ch_ok    = 32'(ch_sel) < N;
	assign is_tick  = kind_s1 == crtb_pkg::KIND_TICK;
	assign is_read  = (kind_s1 == crtb_pkg::KIND_READ) && ch_ok;
	assign is_write = (kind_s1 == crtb_pkg::KIND_WRITE) && ch_ok;
	assign next_div = div_q + 12'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q <= '0;
		end else if (advance && is_tick) begin
			div_q <= next_div;
		end
	end

	assign carry[0] = 1'b0;

	for (genvar c = 0; c < N; c++) begin : g_chan
		logic sel;
		assign sel           = 32'(ch_sel) == c;
		assign cmd[c].tick   = advance && is_tick;
		assign cmd[c].wr_lo  = advance && is_write && sel && (byte_sel == crtb_pkg::BYTE_LO);
		assign cmd[c].wr_hi  = advance && is_write && sel && (byte_sel == crtb_pkg::BYTE_HI);
		assign cmd[c].wr_ctl = advance && is_write && sel && (byte_sel == crtb_pkg::BYTE_CTL);
		assign cmd[c].data   = data_s1;

		crtb_channel u_chan (
			.clk      (clk),
			.arst_n   (arst_n),
			.is_first (c == 0),
			.cmd      (cmd[c]),
			.next_div (next_div),
			.carry_in (carry[c]),
			.stat     (stat[c])
		);

		// a stopped channel never wraps, so the chain stops there
		assign carry[c+1] = stat[c].wrap;
	end

	for (genvar b = 0; b < crtb_pkg::IRQ_W; b++) begin : g_irq
		if (b < N) begin : g_on
			assign irq_vec[b] = stat[b].irq;
		end else begin : g_off
			assign irq_vec[b] = 1'b0;
		end
	end

	always_comb begin
		read_val = '0;
		for (int c = 0; c < N; c++) begin
			if (32'(ch_sel) == c) begin
				unique case (byte_sel)
					crtb_pkg::BYTE_LO:   read_val = stat[c].count[7:0];
					crtb_pkg::BYTE_HI:   read_val = stat[c].count[15:8];
					crtb_pkg::BYTE_CTL:  read_val = stat[c].ctl;
					crtb_pkg::BYTE_CTLH: read_val = '0;
					default:             read_val = '0;
				endcase
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_s2 <= is_read ? read_val : 8'd0;
			irq_s2       <= is_tick ? irq_vec : '0;
		end
	end

	assign rsp.valid      = valid_s2;
	assign rsp.read_data  = read_data_s2;
	assign rsp.irq_raised = irq_s2;

	// only ticks can raise interrupts
	a_irq_only_tick: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_tick |=> irq_s2 == '0)
		else $error("interrupt raised on a non-tick item");

	// reads never come with data on ticks or writes
	a_read_only_read: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !is_read |=> read_data_s2 == 8'd0)
		else $error("read data on a non-read item");

	// divider moves by exactly one per processed tick
	a_div_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && is_tick |=> div_q == 12'($past(div_q) + 12'd1))
		else $error("divider did not advance by one");

	// input stage only blocks while it holds an item that cannot move
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && valid_s2 && !rsp.ready)
		else $error("input stalled without a blocked response");

endmodule
